@@ rtl/core/bpd_pkg.sv @@
// Shared types and constants of the button press duration classifier.
// No dependencies; imported by every module of the block.
package bpd_pkg;

    localparam int COUNT_W   = 8;
    localparam int IN_FIELDS = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = CFG_IDX_W'(1);

    localparam logic [COUNT_W-1:0] SHORT_MIN_RESET = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] LONG_RESET      = COUNT_W'(10);

    typedef enum logic [1:0] {
        CLS_OFF   = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2,
        CLS_XLONG = 2'd3
    } press_class_t;

    typedef struct packed {
        logic [COUNT_W-1:0] short_min;
        logic [COUNT_W-1:0] long_lim;
    } limits_t;

    typedef struct packed {
        logic         held;
        press_class_t cls_cur;
        press_class_t cls_next;
        logic         changed;
    } lane_result_t;

    typedef struct packed {
        press_class_t [IN_FIELDS-1:0] cls;
        logic                         any_pressed;
        logic                         notify;
    } result_word_t;

endpackage

@@ rtl/core/bpd_lane.sv @@
// One button lane: hold counter and press class, updated once per accepted word.
// Depends on bpd_pkg.
module bpd_lane
    import bpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         held,
    input  limits_t      limits,
    output lane_result_t result
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    press_class_t       class_reg;
    press_class_t       class_next;
    logic [COUNT_W-1:0] count_inc;

    always_comb
    begin
        count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + COUNT_W'(1);
        if (held)
        begin
            count_next = count_inc;
            if (class_reg == CLS_LONG)
                class_next = CLS_XLONG;
            else if (class_reg != CLS_XLONG && count_inc > limits.long_lim)
                class_next = CLS_LONG;
            else
                class_next = class_reg;
        end
        else
        begin
            count_next = '0;
            if (count_reg > limits.short_min && count_reg < limits.long_lim)
                class_next = CLS_SHORT;
            else
                class_next = CLS_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            class_reg <= CLS_OFF;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            class_reg <= class_next;
        end
    end

    assign result.held     = held;
    assign result.cls_cur  = class_reg;
    assign result.cls_next = class_next;
    assign result.changed  = (class_next != class_reg);

endmodule

@@ rtl/core/bpd_merge.sv @@
// Merge stage: combines the lane results into one result word and holds it
// in an output register with a skid entry. Depends on bpd_pkg.
module bpd_merge
    import bpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 3
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  lane_result_t [NUM_BUTTONS-1:0] lanes,
    output logic                          full,
    output logic                          out_valid,
    input  logic                          out_stall,
    output result_word_t                  out_word
);

    result_word_t word_next;
    result_word_t out_reg;
    result_word_t skid_reg;
    logic         out_valid_reg;
    logic         skid_valid_reg;
    logic         any_held;
    logic         any_changed;
    logic         take_out;

    always_comb
    begin
        any_held    = 1'b0;
        any_changed = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            any_held    = any_held | lanes[i].held;
            any_changed = any_changed | lanes[i].changed;
        end
    end

    for (genvar i = 0; i < IN_FIELDS; i++)
    begin : g_field
        if (i < NUM_BUTTONS)
        begin : g_lane
            assign word_next.cls[i] = lanes[i].cls_next;
        end
        else
        begin : g_none
            assign word_next.cls[i] = CLS_OFF;
        end
    end

    assign word_next.any_pressed = any_held;
    assign word_next.notify      = any_changed | ~any_held;

    assign take_out = out_valid_reg & ~out_stall;

    // advance the output register, park a word in the skid entry when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take_out)
                skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || take_out)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (take_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take_out)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (!out_valid_reg || take_out)
                out_reg <= word_next;
            else
                skid_reg <= word_next;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

@@ rtl/core/button_press_duration_classifier.sv @@
// Button press duration classifier: one result word per sampling word.
// Throughput 1 word per cycle while item_stall is low; the result word is registered in the merge stage.
// Every button lane updates its counter and class in the accepting cycle; the
// merge stage registers the word, with one skid entry to absorb output stalls.
// Reset (rst_n low, asynchronous) clears counters, classes and valid flags and
// loads short_min_count = 1, long_count = 10.
module button_press_duration_classifier
    import bpd_pkg::*;
#(
    parameter int NUM_BUTTONS = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 up_pressed,
    input  logic                 center_pressed,
    input  logic                 down_pressed,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           up_class,
    output logic [1:0]           center_class,
    output logic [1:0]           down_class,
    output logic                 any_pressed,
    output logic                 notify,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data
);

    limits_t                        limits_reg;
    logic                           accept;
    logic                           merge_full;
    logic [IN_FIELDS-1:0]           pressed_vec;
    lane_result_t [NUM_BUTTONS-1:0] lanes;
    result_word_t                   out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.short_min <= SHORT_MIN_RESET;
            limits_reg.long_lim  <= LONG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHORT_MIN: limits_reg.short_min <= cfg_data;
                REG_LONG:      limits_reg.long_lim  <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign item_stall  = merge_full;
    assign accept      = item_valid & ~item_stall;
    assign pressed_vec = {down_pressed, center_pressed, up_pressed};

    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        logic held;
        if (i < IN_FIELDS)
        begin : g_driven
            assign held = pressed_vec[i];
        end
        else
        begin : g_idle
            assign held = 1'b0;
        end

        bpd_lane u_lane
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (accept),
            .held    (held),
            .limits  (limits_reg),
            .result  (lanes[i])
        );
    end

    bpd_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .lanes     (lanes),
        .full      (merge_full),
        .out_valid (result_valid),
        .out_stall (result_stall),
        .out_word  (out_word)
    );

    assign up_class     = 2'(out_word.cls[0]);
    assign center_class = 2'(out_word.cls[1]);
    assign down_class   = 2'(out_word.cls[2]);
    assign any_pressed  = out_word.any_pressed;
    assign notify       = out_word.notify;

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    a_idle_notifies: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (notify || any_pressed))
        else $error("result without press lacks notify");

    a_long_to_xlong: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && lanes[0].held && lanes[0].cls_cur == CLS_LONG)
            |=> (lanes[0].cls_cur == CLS_XLONG))
        else $error("held long press did not become extra long");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for button_press_duration_classifier: a directed table, then random
// press sequences, each result word checked against the table or an in-bench classifier. Needs bpd_pkg.
module tb
    import bpd_pkg::*;
;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        press_class_t up_cls;
        press_class_t center_cls;
        press_class_t down_cls;
        logic         any_held;
        logic         notify_flag;
    } class_word_t;

    typedef enum logic {
        ROW_TICK,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [2:0]            lvl;
        logic [CFG_IDX_W-1:0]  idx;
        logic [COUNT_W-1:0]    val;
        bit                    typed;
        class_word_t           want;
    } step_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    logic                 up_pressed;
    logic                 center_pressed;
    logic                 down_pressed;
    logic                 result_valid;
    logic                 result_stall;
    logic [1:0]           up_class;
    logic [1:0]           center_class;
    logic [1:0]           down_class;
    logic                 any_pressed;
    logic                 notify;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0]   cfg_data;

    // classifier state
    logic [COUNT_W-1:0] hold_cnt[3];
    press_class_t       btn_cls[3];
    logic [COUNT_W-1:0] short_lim;
    logic [COUNT_W-1:0] long_lim;

    class_word_t  class_q[$];
    step_row_t    plan[$];
    class_word_t  seen_want;

    int  run_left[3];
    bit  level[3];
    bit  noisy;
    int  src_calm;
    int  dst_calm;
    int  dst_hold;
    bit  holdoff_done;
    int  words_sent;
    int  words_checked;
    int  regs_written;
    int  mismatches;
    int  quiet_cycles;

    button_press_duration_classifier i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .up_pressed     (up_pressed),
        .center_pressed (center_pressed),
        .down_pressed   (down_pressed),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .up_class       (up_class),
        .center_class   (center_class),
        .down_class     (down_class),
        .any_pressed    (any_pressed),
        .notify         (notify),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Advance every button by one tick; lvl is {up, center, down}.
    function automatic class_word_t classify_tick(input logic [2:0] lvl);
        class_word_t        w;
        logic               changed;
        logic               held_any;
        press_class_t       prev;
        logic [COUNT_W-1:0] cnt;
        changed = 1'b0;
        held_any = 1'b0;
        for (int b = 0; b < 3; b++)
        begin
            prev = btn_cls[b];
            cnt = hold_cnt[b];
            if (lvl[2-b])
            begin
                held_any = 1'b1;
                if (cnt != COUNT_MAX)
                    cnt = cnt + COUNT_W'(1);
                if (btn_cls[b] == CLS_LONG)
                    btn_cls[b] = CLS_XLONG;
                else if (btn_cls[b] != CLS_XLONG && cnt > long_lim)
                    btn_cls[b] = CLS_LONG;
                hold_cnt[b] = cnt;
            end
            else
            begin
                btn_cls[b] = (cnt > short_lim && cnt < long_lim) ? CLS_SHORT : CLS_OFF;
                hold_cnt[b] = '0;
            end
            if (btn_cls[b] != prev)
                changed = 1'b1;
        end
        w.up_cls = btn_cls[0];
        w.center_cls = btn_cls[1];
        w.down_cls = btn_cls[2];
        w.any_held = held_any;
        w.notify_flag = changed || !held_any;
        return w;
    endfunction

    function automatic int idle_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int hold_len();
        int r;
        int reach;
        r = $urandom_range(0, 99);
        reach = (int'(long_lim) > 30) ? 30 : int'(long_lim);
        if (r < 55)
            return $urandom_range(1, reach + 3);
        if (r < 95)
            return $urandom_range(1, 6);
        return $urandom_range(200, 300);
    endfunction

    function automatic logic [2:0] next_levels();
        logic [2:0] lvl;
        for (int b = 0; b < 3; b++)
        begin
            if (run_left[b] == 0)
            begin
                level[b] = !level[b];
                run_left[b] = level[b] ? hold_len() : $urandom_range(1, 4);
            end
            run_left[b]--;
        end
        lvl = {level[0], level[1], level[2]};
        if (noisy && $urandom_range(0, 9) == 0)
            lvl = 3'($urandom_range(0, 7));
        return lvl;
    endfunction

    function automatic step_row_t row_tick(input logic [2:0] lvl);
        step_row_t s;
        s.kind = ROW_TICK;
        s.lvl = lvl;
        s.idx = '0;
        s.val = '0;
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_row_t row_tick_is(input logic [2:0] lvl, input press_class_t u,
                                              input press_class_t c, input press_class_t d,
                                              input logic a, input logic n);
        step_row_t s;
        s = row_tick(lvl);
        s.typed = 1'b1;
        s.want.up_cls = u;
        s.want.center_cls = c;
        s.want.down_cls = d;
        s.want.any_held = a;
        s.want.notify_flag = n;
        return s;
    endfunction

    function automatic step_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [COUNT_W-1:0] val);
        step_row_t s;
        s = row_tick('0);
        s.kind = ROW_REG;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    task automatic send_word(input logic [2:0] lvl, input bit typed, input class_word_t want);
        int          gap;
        class_word_t calc;
        gap = idle_gap(src_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        {up_pressed, center_pressed, down_pressed} <= lvl;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        calc = classify_tick(lvl);
        class_q.push_back(typed ? want : calc);
        words_sent++;
        @(negedge clk);
    endtask

    // Hold the sender until every result word is back, then let the pipe empty.
    task automatic settle();
        item_valid <= 1'b0;
        while (class_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_SHORT_MIN)
            short_lim = val;
        else if (idx == REG_LONG)
            long_lim = val;
        regs_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_field(input string what, input logic [1:0] want, input logic [1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (class_q.size() == 0)
            begin
                $display("%0t: result word expected none got %0d %0d %0d %0d %0d", $time,
                         up_class, center_class, down_class, any_pressed, notify);
                mismatches++;
            end
            else
            begin
                seen_want = class_q.pop_front();
                check_field("up_class", seen_want.up_cls, up_class);
                check_field("center_class", seen_want.center_cls, center_class);
                check_field("down_class", seen_want.down_cls, down_class);
                check_field("any_pressed", {1'b0, seen_want.any_held}, {1'b0, any_pressed});
                check_field("notify", {1'b0, seen_want.notify_flag}, {1'b0, notify});
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("button_press_duration_classifier verification failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off once traffic is under way.
    initial
    begin
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (dst_hold > 0)
                dst_hold--;
            else if (!holdoff_done && words_sent >= 200)
            begin
                holdoff_done = 1'b1;
                dst_hold = 64;
            end
            else
                dst_hold = idle_gap(dst_calm);
            result_stall <= (dst_hold > 0);
        end
    end

    initial
    begin
        int lo;
        int hi;
        int n;
        rst_n = 1'b0;
        item_valid = 1'b0;
        up_pressed = 1'b0;
        center_pressed = 1'b0;
        down_pressed = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        short_lim = SHORT_MIN_RESET;
        long_lim = LONG_RESET;
        for (int b = 0; b < 3; b++)
        begin
            hold_cnt[b] = '0;
            btn_cls[b] = CLS_OFF;
        end

        plan.push_back(row_tick_is(3'b000, CLS_OFF, CLS_OFF, CLS_OFF, 1'b0, 1'b1));
        plan.push_back(row_tick_is(3'b111, CLS_OFF, CLS_OFF, CLS_OFF, 1'b1, 1'b0));
        plan.push_back(row_tick(3'b111));
        plan.push_back(row_tick(3'b100));
        plan.push_back(row_tick(3'b000));
        plan.push_back(row_reg(REG_LONG, 8'd0));
        plan.push_back(row_reg(REG_SHORT_MIN, 8'd255));
        plan.push_back(row_tick_is(3'b010, CLS_OFF, CLS_LONG, CLS_OFF, 1'b1, 1'b1));
        plan.push_back(row_tick_is(3'b010, CLS_OFF, CLS_XLONG, CLS_OFF, 1'b1, 1'b1));
        plan.push_back(row_tick_is(3'b010, CLS_OFF, CLS_XLONG, CLS_OFF, 1'b1, 1'b0));
        plan.push_back(row_tick_is(3'b000, CLS_OFF, CLS_OFF, CLS_OFF, 1'b0, 1'b1));
        plan.push_back(row_reg(CFG_IDX_W'(2), 8'h55));
        plan.push_back(row_reg(CFG_IDX_W'(255), 8'hAA));
        plan.push_back(row_tick_is(3'b001, CLS_OFF, CLS_OFF, CLS_LONG, 1'b1, 1'b1));
        plan.push_back(row_tick_is(3'b000, CLS_OFF, CLS_OFF, CLS_OFF, 1'b0, 1'b1));
        plan.push_back(row_reg(REG_SHORT_MIN, 8'd0));
        plan.push_back(row_reg(REG_LONG, 8'd255));
        plan.push_back(row_tick(3'b111));
        plan.push_back(row_tick(3'b111));
        plan.push_back(row_tick(3'b011));
        plan.push_back(row_tick(3'b101));
        plan.push_back(row_tick(3'b000));
        plan.push_back(row_tick(3'b110));
        plan.push_back(row_tick(3'b000));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
                send_word(plan[i].lvl, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 6; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    lo = 1;
                    hi = 10;
                end
                1:
                begin
                    lo = 0;
                    hi = 255;
                end
                2:
                begin
                    lo = 255;
                    hi = 0;
                end
                3:
                begin
                    lo = 0;
                    hi = 1;
                end
                default:
                begin
                    lo = $urandom_range(0, 8);
                    hi = lo + $urandom_range(0, 16);
                end
            endcase
            write_reg(REG_SHORT_MIN, COUNT_W'(lo));
            write_reg(REG_LONG, COUNT_W'(hi));
            write_reg(CFG_IDX_W'($urandom_range(2, 255)), COUNT_W'($urandom));
            for (int b = 0; b < 3; b++)
            begin
                level[b] = 1'b0;
                run_left[b] = $urandom_range(0, 3);
            end
            noisy = (p != 1);
            n = 100;
            // hold up past the counter ceiling
            if (p == 1)
            begin
                level[0] = 1'b1;
                run_left[0] = 270;
                n = 290;
            end
            repeat (n) send_word(next_levels(), 1'b0, '0);
        end
        settle();

        $display("%0d sampling words sent, %0d result words checked, %0d register writes",
                 words_sent, words_checked, regs_written);
        $display("limits covered: default, both extremes, reversed order, random windows");
        if (mismatches == 0 && class_q.size() == 0)
            $display("button_press_duration_classifier verification clean");
        else
            $display("button_press_duration_classifier verification failed");
        $finish;
    end

endmodule
